// ----- sv/efifo_pkg.sv -----
// ----------------------------------------------------------------------------
// efifo_pkg
// Shared constants, operation codes and a capacity helper for the elastic word FIFO.
// ----------------------------------------------------------------------------
package efifo_pkg;

  // default sizing
  localparam int MIN_WORDS_DEF = 512;
  localparam int MAX_WORDS_DEF = 4096;
  localparam int WORD_BITS_DEF = 64;

  // configuration register
  localparam int          CFG_BITS       = 4;
  localparam int          APB_DATA_BITS  = 32;
  localparam int          APB_ADDR_BITS  = 3;
  localparam logic        REG_INIT_LOG2  = 1'b0;
  localparam logic [3:0]  INIT_LOG2_RST  = 4'd9;

  // operation codes
  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_POP    = 2'd1;
  localparam logic [1:0] MODE_SHRINK = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  // capacity for a given log2 request, kept between min and max
  // (both are powers of two)
  function automatic int cap_from_log2(int lg, int min_w, int max_w);
    int t;
    t = 1 << lg;
    if (t < min_w) return min_w;
    if (t > max_w) return max_w;
    return t;
  endfunction

endpackage

// ----- sv/elastic_word_fifo.sv -----
// ----------------------------------------------------------------------------
// elastic_word_fifo
// Growable circular word FIFO built around a single-port-pair word memory.
// ----------------------------------------------------------------------------
// Push, pop, clear and shrinks that move nothing: result strobe in the cycle
// after accept; one item per cycle sustained.
// A growing push with wrapped data moves write_index words before done. A
// compacting shrink moves the live words, in two copy passes when the data
// wraps.
// The read-then-write copy runs one word per cycle through the memory.
// Reset (synchronous) empties the queue with no clearing pass.
// Results cannot be stalled; done is a one-cycle strobe.
module elastic_word_fifo
  import efifo_pkg::*;
#(
  parameter int MIN_WORDS = MIN_WORDS_DEF,
  parameter int MAX_WORDS = MAX_WORDS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // item channel
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 mode,
  input  logic [WORD_BITS-1:0]       push_data,
  // result channel
  output logic                       done,
  output logic                       ok,
  output logic [WORD_BITS-1:0]       pop_data,
  output logic                       grew,
  output logic [$clog2(MAX_WORDS):0] words_used,
  output logic [$clog2(MAX_WORDS):0] capacity_words,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [APB_ADDR_BITS-1:0]   paddr,
  input  logic [APB_DATA_BITS-1:0]   pwdata,
  output logic [APB_DATA_BITS-1:0]   prdata,
  output logic                       pready
);

  localparam int AW = $clog2(MAX_WORDS);
  localparam int CW = AW + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_COPY = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // queue state
  logic [AW-1:0] windex, rindex;
  logic [CW-1:0] count, cap;
  logic [CW-1:0] init_cap;

  // sequencer
  logic [1:0]    state;
  logic [AW-1:0] src, dst;
  logic [CW-1:0] remain;
  logic          dir_down;
  logic          ph2_valid;
  logic [AW-1:0] ph2_src;
  logic [CW-1:0] ph2_len;
  logic          pend_valid;
  logic [AW-1:0] pend_dst;
  logic          fin_push;
  logic [AW-1:0] fin_addr;
  logic [WORD_BITS-1:0] fin_data;

  // result registers
  logic          ok_r, grew_r, pop_sel;
  logic [CW-1:0] used_r, capw_r;

  // memory ports
  logic                 we, re;
  logic [AW-1:0]        waddr, raddr;
  logic [WORD_BITS-1:0] wdata, rdata;

  // decode results
  logic          accept;
  logic [AW-1:0] w_n, r_n;
  logic [CW-1:0] cnt_n, cap_n;
  logic          ok_n, grew_n, popok_n;
  logic          imm_we;
  logic [AW-1:0] imm_addr;
  logic          need_copy;
  logic [AW-1:0] c_src, c_dst;
  logic [CW-1:0] c_len;
  logic          c_down, c2_valid;
  logic [AW-1:0] c2_src;
  logic [CW-1:0] c2_len;
  logic          finp_n;
  logic [AW-1:0] fina_n;

  logic          full, can_grow, can_shrink, wrapped, issue;
  logic [CW:0]   cap2;
  logic [CW-1:0] half, head_len;
  logic [AW-1:0] base_w;

  efifo_cfg #(
    .MIN_WORDS (MIN_WORDS),
    .MAX_WORDS (MAX_WORDS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .init_cap (init_cap)
  );

  efifo_ram #(
    .DEPTH (MAX_WORDS),
    .WIDTH (WORD_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign issue  = (state == ST_COPY) && (remain != '0);

  // shared conditions
  assign full       = (count == cap);
  assign cap2       = {cap, 1'b0};
  assign can_grow   = (cap2 <= (CW+1)'(MAX_WORDS));
  assign half       = cap >> 1;
  assign can_shrink = (count <= half) && (half >= CW'(MIN_WORDS));
  assign head_len   = cap - {1'b0, rindex};
  assign wrapped    = (count > head_len);
  assign base_w     = cap[AW-1:0] + windex;

  // operation decode against the current state
  always_comb begin
    w_n       = windex;
    r_n       = rindex;
    cnt_n     = count;
    cap_n     = cap;
    ok_n      = 1'b0;
    grew_n    = 1'b0;
    popok_n   = 1'b0;
    imm_we    = 1'b0;
    imm_addr  = windex;
    need_copy = 1'b0;
    c_src     = '0;
    c_dst     = '0;
    c_len     = '0;
    c_down    = 1'b0;
    c2_valid  = 1'b0;
    c2_src    = '0;
    c2_len    = '0;
    finp_n    = 1'b0;
    fina_n    = base_w;
    unique case (mode)
      MODE_PUSH: begin
        if (!full) begin
          imm_we = 1'b1;
          w_n    = (windex + AW'(1)) & (cap[AW-1:0] - AW'(1));
          cnt_n  = count + CW'(1);
          ok_n   = 1'b1;
        end else if (can_grow) begin
          // wrapped prefix moves up by the old capacity
          grew_n = 1'b1;
          ok_n   = 1'b1;
          cap_n  = cap2[CW-1:0];
          cnt_n  = count + CW'(1);
          w_n    = (base_w + AW'(1)) & (cap2[AW-1:0] - AW'(1));
          if (windex != '0) begin
            need_copy = 1'b1;
            finp_n    = 1'b1;
            c_src     = '0;
            c_dst     = cap[AW-1:0];
            c_len     = {1'b0, windex};
          end else begin
            imm_we   = 1'b1;
            imm_addr = base_w;
          end
        end
      end
      MODE_POP: begin
        if (count != '0) begin
          popok_n = 1'b1;
          ok_n    = 1'b1;
          r_n     = (rindex + AW'(1)) & (cap[AW-1:0] - AW'(1));
          cnt_n   = count - CW'(1);
        end
      end
      MODE_SHRINK: begin
        if (can_shrink) begin
          ok_n  = 1'b1;
          cap_n = half;
          r_n   = '0;
          w_n   = count[AW-1:0] & (half[AW-1:0] - AW'(1));
          if (count != '0 && rindex != '0) begin
            need_copy = 1'b1;
            if (wrapped) begin
              // low part moves up behind the head part, top down
              c_src    = windex - AW'(1);
              c_dst    = head_len[AW-1:0] + windex - AW'(1);
              c_len    = {1'b0, windex};
              c_down   = 1'b1;
              c2_valid = 1'b1;
              c2_src   = rindex;
              c2_len   = head_len;
            end else begin
              c_src = rindex;
              c_dst = '0;
              c_len = count;
            end
          end
        end
      end
      MODE_CLEAR: begin
        ok_n  = 1'b1;
        w_n   = '0;
        r_n   = '0;
        cnt_n = '0;
        cap_n = init_cap;
      end
      default: begin
      end
    endcase
  end

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = imm_addr;
    wdata = push_data;
    if (pend_valid) begin
      we    = 1'b1;
      waddr = pend_dst;
      wdata = rdata;
    end else if (state == ST_FIN && fin_push) begin
      we    = 1'b1;
      waddr = fin_addr;
      wdata = fin_data;
    end else if (accept && imm_we) begin
      we = 1'b1;
    end
  end

  assign re    = issue || (accept && popok_n);
  assign raddr = issue ? src : rindex;

  // state, sequencer and results
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      windex     <= '0;
      rindex     <= '0;
      count      <= '0;
      cap        <= CW'(cap_from_log2(int'(INIT_LOG2_RST), MIN_WORDS, MAX_WORDS));
      pend_valid <= 1'b0;
      ph2_valid  <= 1'b0;
      done       <= 1'b0;
      pop_sel    <= 1'b0;
    end else begin
      done       <= 1'b0;
      pend_valid <= issue;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            windex   <= w_n;
            rindex   <= r_n;
            count    <= cnt_n;
            cap      <= cap_n;
            ok_r     <= ok_n;
            grew_r   <= grew_n;
            used_r   <= cnt_n;
            capw_r   <= cap_n;
            pop_sel  <= popok_n;
            fin_push <= finp_n;
            fin_addr <= fina_n;
            fin_data <= push_data;
            if (need_copy) begin
              state     <= ST_COPY;
              src       <= c_src;
              dst       <= c_dst;
              remain    <= c_len;
              dir_down  <= c_down;
              ph2_valid <= c2_valid;
              ph2_src   <= c2_src;
              ph2_len   <= c2_len;
            end else begin
              done <= 1'b1;
            end
          end
        end
        ST_COPY: begin
          if (issue) begin
            pend_dst <= dst;
            remain   <= remain - CW'(1);
            if (dir_down) begin
              src <= src - AW'(1);
              dst <= dst - AW'(1);
            end else begin
              src <= src + AW'(1);
              dst <= dst + AW'(1);
            end
          end else if (ph2_valid) begin
            // second pass: head part down to index 0
            ph2_valid <= 1'b0;
            src       <= ph2_src;
            dst       <= '0;
            remain    <= ph2_len;
            dir_down  <= 1'b0;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          // last copy write drains first, then the pushed word lands
          if (!pend_valid) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign ok             = ok_r;
  assign grew           = grew_r;
  assign words_used     = used_r;
  assign capacity_words = capw_r;
  assign pop_data       = pop_sel ? rdata : '0;

endmodule

// ----- sv/efifo_ram.sv -----
// ----------------------------------------------------------------------------
// efifo_ram
// Word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module efifo_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/efifo_cfg.sv -----
// ----------------------------------------------------------------------------
// efifo_cfg
// APB register holding the initial capacity log2; derives the capacity.
// ----------------------------------------------------------------------------
module efifo_cfg
  import efifo_pkg::*;
#(
  parameter int MIN_WORDS = MIN_WORDS_DEF,
  parameter int MAX_WORDS = MAX_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_ADDR_BITS-1:0]     paddr,
  input  logic [APB_DATA_BITS-1:0]     pwdata,
  output logic [APB_DATA_BITS-1:0]     prdata,
  output logic                         pready,
  output logic [$clog2(MAX_WORDS):0]   init_cap
);

  localparam int CW = $clog2(MAX_WORDS) + 1;

  logic [CFG_BITS-1:0] init_log2;
  logic                sel_reg;

  // word index of the access
  assign sel_reg = (paddr[2] == REG_INIT_LOG2);
  assign pready  = 1'b1;

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      init_log2 <= INIT_LOG2_RST;
    end else if (psel && penable && pwrite && sel_reg) begin
      init_log2 <= pwdata[CFG_BITS-1:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (sel_reg) begin
      prdata[CFG_BITS-1:0] = init_log2;
    end
  end

  assign init_cap = CW'(cap_from_log2(int'(init_log2), MIN_WORDS, MAX_WORDS));

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for elastic_word_fifo. A behavioral ring model predicts
// the result of every accepted item (push, pop, shrink, clear). Each strobed
// result is checked field by field against the oldest prediction. Directed
// tests cover the empty and full corners, growth with wrapped data, shrink
// compaction and the capacity register. A random phase follows, using fill
// and drain bursts under several register settings.
// ----------------------------------------------------------------------------
module testbench;
  import efifo_pkg::*;

  localparam int CAP_MIN = MIN_WORDS_DEF;
  localparam int CAP_MAX = MAX_WORDS_DEF;
  localparam int DW      = WORD_BITS_DEF;
  localparam int CW      = $clog2(CAP_MAX) + 1;
  localparam logic [APB_ADDR_BITS-1:0] INIT_LOG2_ADDR = APB_ADDR_BITS'(4 * REG_INIT_LOG2);

  typedef struct packed {
    logic          ok;
    logic [DW-1:0] pop_data;
    logic          grew;
    logic [CW-1:0] words_used;
    logic [CW-1:0] capacity_words;
  } fifo_result_t;

  // clock, reset and DUT ports
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               mode = MODE_PUSH;
  logic [DW-1:0]            push_data = '0;
  logic                     done;
  logic                     ok;
  logic [DW-1:0]            pop_data;
  logic                     grew;
  logic [CW-1:0]            words_used;
  logic [CW-1:0]            capacity_words;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  // ring model state
  logic [DW-1:0] ring_words  [CAP_MAX];
  logic [DW-1:0] compact_buf [CAP_MAX];
  int            ring_wr;
  int            ring_rd;
  int            ring_count;
  int            ring_cap;
  logic [3:0]    cfg_log2;

  fifo_result_t  pending_results [$];
  int            mismatches = 0;
  bit            idle_on = 1'b1;

  elastic_word_fifo dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .mode(mode), .push_data(push_data),
    .done(done), .ok(ok), .pop_data(pop_data), .grew(grew),
    .words_used(words_used), .capacity_words(capacity_words),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // capacity picked on reset and clear for a given register value
  function automatic int cap_for_log2(logic [3:0] lg);
    int target, c;
    target = 1 << lg;
    c = CAP_MIN;
    while (c < target && c < CAP_MAX) c = c * 2;
    return c;
  endfunction

  function automatic void ring_reinit();
    ring_wr    = 0;
    ring_rd    = 0;
    ring_count = 0;
    ring_cap   = cap_for_log2(cfg_log2);
  endfunction

  // apply one item to the ring model and return the result it produces
  function automatic fifo_result_t fifo_apply(logic [1:0] op, logic [DW-1:0] word);
    fifo_result_t r;
    int old_cap, half, i;
    r = '0;
    case (op)
      MODE_PUSH: begin
        if (ring_count >= ring_cap && ring_cap * 2 <= CAP_MAX) begin
          old_cap = ring_cap;
          // wrapped data: low segment moves above the old end
          if (ring_count > 0 && ring_rd >= ring_wr) begin
            for (i = 0; i < ring_wr; i++) ring_words[old_cap + i] = ring_words[i];
            ring_wr = old_cap + ring_wr;
          end
          ring_cap = old_cap * 2;
          r.grew = 1'b1;
        end
        if (ring_count < ring_cap) begin
          ring_words[ring_wr] = word;
          ring_wr = (ring_wr + 1) & (ring_cap - 1);
          ring_count++;
          r.ok = 1'b1;
        end
      end
      MODE_POP: begin
        if (ring_count > 0) begin
          r.pop_data = ring_words[ring_rd];
          ring_rd = (ring_rd + 1) & (ring_cap - 1);
          ring_count--;
          r.ok = 1'b1;
        end
      end
      MODE_SHRINK: begin
        half = ring_cap / 2;
        if (ring_count <= half && half >= CAP_MIN) begin
          // compact live words to index 0, oldest first
          for (i = 0; i < ring_count; i++)
            compact_buf[i] = ring_words[(ring_rd + i) & (ring_cap - 1)];
          for (i = 0; i < ring_count; i++) ring_words[i] = compact_buf[i];
          ring_cap = half;
          ring_rd  = 0;
          ring_wr  = ring_count & (half - 1);
          r.ok = 1'b1;
        end
      end
      default: begin
        ring_reinit();
        r.ok = 1'b1;
      end
    endcase
    r.words_used     = CW'(ring_count);
    r.capacity_words = CW'(ring_cap);
    return r;
  endfunction

  function automatic logic [DW-1:0] rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 64'h1 << $urandom_range(DW - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic check_field(string field, logic [DW-1:0] want, logic [DW-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %h, got %h", $time, field, want, got);
    end
  endtask

  // result checker: each strobe takes the oldest prediction
  always @(posedge clk) begin : result_check
    fifo_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result with no item pending", $time);
      end else begin
        want = pending_results.pop_front();
        check_field("ok", want.ok, ok);
        check_field("pop_data", want.pop_data, pop_data);
        check_field("grew", want.grew, grew);
        check_field("words_used", want.words_used, words_used);
        check_field("capacity_words", want.capacity_words, capacity_words);
      end
    end
  end

  // send one item; returns in the time step of the accepting edge
  task automatic send_item(logic [1:0] op, logic [DW-1:0] word);
    while (idle_on && $urandom_range(99) < 26) begin
      start     <= 1'b0;
      mode      <= 2'($urandom);
      push_data <= rand_word();
      @(posedge clk);
    end
    start     <= 1'b1;
    mode      <= op;
    push_data <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(fifo_apply(op, word));
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic wait_drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write: setup then access cycle; upper data bits carry noise
  task automatic write_init_log2(logic [3:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= INIT_LOG2_ADDR;
    pwdata  <= (APB_DATA_BITS'($urandom) & ~APB_DATA_BITS'(15)) | APB_DATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_log2 = value;
  endtask

  // empty-queue corners, data extremes, every operation
  task automatic test_empty_ops();
    send_item(MODE_POP, rand_word());
    send_item(MODE_SHRINK, rand_word());
    send_item(MODE_PUSH, '0);
    send_item(MODE_PUSH, '1);
    send_item(MODE_PUSH, 64'h8000_0000_0000_0001);
    repeat (3) send_item(MODE_POP, rand_word());
    send_item(MODE_POP, rand_word());
    send_item(MODE_PUSH, rand_word());
    send_item(MODE_CLEAR, rand_word());
    send_item(MODE_POP, rand_word());
    send_item(MODE_CLEAR, rand_word());
  endtask

  // growth with wrapped data, exact-fit shrink, wrapped compaction
  task automatic test_grow_and_shrink();
    send_item(MODE_CLEAR, rand_word());
    repeat (100) send_item(MODE_PUSH, rand_word());
    repeat (100) send_item(MODE_POP, rand_word());
    repeat (CAP_MIN) send_item(MODE_PUSH, rand_word());
    send_item(MODE_PUSH, rand_word());      // grows, copies the wrapped part
    send_item(MODE_POP, rand_word());
    send_item(MODE_SHRINK, rand_word());    // live count equals new capacity
    send_item(MODE_PUSH, rand_word());      // grows again, nothing wrapped
    repeat (300) send_item(MODE_POP, rand_word());
    repeat (600) send_item(MODE_PUSH, rand_word());
    repeat (500) send_item(MODE_POP, rand_word());
    send_item(MODE_SHRINK, rand_word());    // compacts wrapped data
    repeat (313) send_item(MODE_POP, rand_word());
    send_item(MODE_POP, rand_word());
  endtask

  // fill to the top capacity with every growth wrapped, then drain
  task automatic test_fill_to_top();
    send_item(MODE_CLEAR, rand_word());
    repeat (37) send_item(MODE_PUSH, rand_word());
    repeat (37) send_item(MODE_POP, rand_word());
    repeat (CAP_MAX) send_item(MODE_PUSH, rand_word());
    send_item(MODE_PUSH, rand_word());      // full at top: refused
    send_item(MODE_SHRINK, rand_word());    // too many live words: refused
    repeat (CAP_MAX) send_item(MODE_POP, rand_word());
    send_item(MODE_POP, rand_word());
  endtask

  // capacity register: extremes, out-of-range values, effect only on clear
  task automatic test_capacity_register();
    wait_drain();
    write_init_log2(4'd15);
    send_item(MODE_CLEAR, rand_word());
    repeat (4) send_item(MODE_SHRINK, rand_word());
    wait_drain();
    write_init_log2(4'd0);
    send_item(MODE_CLEAR, rand_word());
    wait_drain();
    write_init_log2(4'd12);
    send_item(MODE_PUSH, rand_word());
    send_item(MODE_CLEAR, rand_word());
    wait_drain();
    write_init_log2(4'd11);
    send_item(MODE_CLEAR, rand_word());
    wait_drain();
    write_init_log2(4'd10);
    send_item(MODE_CLEAR, rand_word());
  endtask

  // random fill and drain bursts, one register setting per phase
  task automatic test_random_traffic();
    logic [3:0] cfg_plan [6] = '{4'd10, 4'd0, 4'd12, 4'd15, 4'd11, 4'd9};
    int         burst_left;
    bit         filling;
    int         r;
    logic [1:0] op;
    burst_left = 0;
    filling    = 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      wait_drain();
      idle_on = (ph != 2);
      write_init_log2(cfg_plan[ph]);
      send_item(MODE_CLEAR, rand_word());
      for (int n = 0; n < 320; n++) begin
        if (burst_left == 0) begin
          filling    = !filling;
          burst_left = $urandom_range(50, 250);
        end
        burst_left--;
        r = $urandom_range(999);
        if (r < 5)                          op = MODE_CLEAR;
        else if (r < 50)                    op = MODE_SHRINK;
        else if (r < (filling ? 750 : 300)) op = MODE_PUSH;
        else                                op = MODE_POP;
        send_item(op, rand_word());
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    cfg_log2 = INIT_LOG2_RST;
    ring_reinit();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_empty_ops();
    wait_drain();
    test_grow_and_shrink();
    wait_drain();
    test_fill_to_top();
    test_capacity_register();
    test_random_traffic();
    wait_drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
